/* rtl/bist_pkg.sv */
// shared types and constants for the bounded integer set table
// no dependencies; used by bist_ctrl, bist_datapath and bounded_integer_set_table

package bist_pkg;

   localparam int KEY_W   = 32;
   localparam int COUNT_W = 7;
   localparam int POS_W   = 6;
   localparam int MODE_W  = 2;
   localparam int RSP_W   = 16;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_ACT,
      ST_MOVE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic step;
      logic hit;
      logic do_add;
      logic do_refuse;
      logic do_remove;
      logic do_move;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic more;
      logic match;
      logic add_miss;
      logic room;
      logic remove_hit;
      logic rsp_free;
   } status_type;

endpackage

/* rtl/bist_ctrl.sv */
// controller state machine for the bounded integer set table
// depends on bist_pkg; drives commands into bist_datapath from its status

module bist_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  bist_pkg::status_type   status,
   output bist_pkg::cmd_type      cmd
);

   bist_pkg::state_type state_ff;
   bist_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bist_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bist_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = bist_pkg::ST_SCAN;
            end
         end
         bist_pkg::ST_SCAN: begin
            if (status.more) begin
               state_in = bist_pkg::ST_CHECK;
            end else begin
               state_in = bist_pkg::ST_ACT;
            end
         end
         bist_pkg::ST_CHECK: begin
            if (status.match) begin
               state_in = bist_pkg::ST_ACT;
            end else begin
               state_in = bist_pkg::ST_SCAN;
            end
         end
         bist_pkg::ST_ACT: begin
            if (status.remove_hit) begin
               state_in = bist_pkg::ST_MOVE;
            end else begin
               state_in = bist_pkg::ST_DONE;
            end
         end
         bist_pkg::ST_MOVE: begin
            state_in = bist_pkg::ST_DONE;
         end
         bist_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               state_in = bist_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bist_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bist_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         bist_pkg::ST_SCAN: begin
            cmd.scan_rd = status.more;
         end
         bist_pkg::ST_CHECK: begin
            cmd.hit  = status.match;
            cmd.step = !status.match;
         end
         bist_pkg::ST_ACT: begin
            cmd.do_add    = status.add_miss && status.room;
            cmd.do_refuse = status.add_miss && !status.room;
            cmd.do_remove = status.remove_hit;
         end
         bist_pkg::ST_MOVE: begin
            cmd.do_move = 1'b1;
         end
         bist_pkg::ST_DONE: begin
            cmd.emit = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/bist_datapath.sv */
// datapath for the bounded integer set table: slot memory, count, scan index, result word
// depends on bist_pkg; steered by commands from bist_ctrl

module bist_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bist_pkg::cmd_type             cmd,
   output bist_pkg::status_type          status,
   input  logic [bist_pkg::MODE_W-1:0]   req_mode,
   input  logic [bist_pkg::KEY_W-1:0]    req_key,
   input  logic [bist_pkg::COUNT_W-1:0]  capacity,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bist_pkg::RSP_W-1:0]    rsp_tdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [bist_pkg::KEY_W-1:0] slots [DEPTH];

   bist_pkg::mode_type               mode_ff, mode_in;
   logic [bist_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [bist_pkg::COUNT_W-1:0]     held_ff, held_in;
   logic [bist_pkg::COUNT_W-1:0]     idx_ff, idx_in;
   logic [bist_pkg::COUNT_W-1:0]     pos_ff, pos_in;
   logic                             found_ff, found_in;
   logic                             refused_ff, refused_in;
   logic [bist_pkg::KEY_W-1:0]       rd_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bist_pkg::RSP_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [AW-1:0]                    rd_addr;
   logic [bist_pkg::COUNT_W-1:0]     last;

   assign last = held_ff - bist_pkg::COUNT_W'(1);

   assign status.more       = idx_ff < held_ff;
   assign status.match      = rd_ff == key_ff;
   assign status.add_miss   = (mode_ff == bist_pkg::MODE_ADD) && !found_ff;
   assign status.room       = (held_ff < capacity) && (32'(held_ff) < 32'(DEPTH));
   assign status.remove_hit = (mode_ff == bist_pkg::MODE_REMOVE) && found_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rd_addr = cmd.do_remove ? AW'(last) : AW'(idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.scan_rd || cmd.do_remove) begin
         rd_ff <= slots[rd_addr];
      end
      if (cmd.do_add) begin
         slots[AW'(held_ff)] <= key_ff;
      end else if (cmd.do_move) begin
         slots[AW'(pos_ff)] <= rd_ff;
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      key_in       = key_ff;
      held_in      = held_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      refused_in   = refused_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load) begin
         mode_in    = bist_pkg::mode_type'(req_mode);
         key_in     = req_key;
         idx_in     = '0;
         pos_in     = '0;
         found_in   = 1'b0;
         refused_in = 1'b0;
         if (bist_pkg::mode_type'(req_mode) == bist_pkg::MODE_CLEAR) begin
            held_in = '0;
         end
      end
      if (cmd.step) begin
         idx_in = idx_ff + bist_pkg::COUNT_W'(1);
      end
      if (cmd.hit) begin
         found_in = 1'b1;
         pos_in   = idx_ff;
      end
      if (cmd.do_add) begin
         pos_in  = held_ff;
         held_in = held_ff + bist_pkg::COUNT_W'(1);
      end
      if (cmd.do_refuse) begin
         refused_in = 1'b1;
      end
      if (cmd.do_remove) begin
         held_in = last;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, refused_ff, held_ff, pos_ff[bist_pkg::POS_W-1:0], found_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      found_ff    <= found_in;
      refused_ff  <= refused_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/bounded_integer_set_table.sv */
// Bounded integer set table: an unsorted set of distinct 32-bit signed keys kept in a
// single-port slot memory of DEPTH entries plus a count. One request word is taken at a
// time. The slot memory is searched one slot at a time, each slot read and then compared.
// A request visits the slots in order: the whole count on a miss, up to and including the
// matching slot on a hit. A hit skips the final scan step, and a remove that hits then
// moves the last entry into the freed slot. Clear visits no slot. The result word is
// registered as the block returns to idle, ready for the next request. The next request is
// taken while a finished result word still waits on the rsp side; that request then holds
// in its last cycle until the waiting word is taken. The user must see that capacity is
// written on the csr channel only while the block is idle; the block itself does not
// enforce this. Values above DEPTH act as DEPTH.
// depends on bist_pkg, bist_ctrl and bist_datapath

module bounded_integer_set_table #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // mode
   input  logic [31:0] req_tdata,   // key
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // found, position[5:0], count[6:0], refused, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // capacity
);

   bist_pkg::cmd_type    cmd;
   bist_pkg::status_type status;

   logic [bist_pkg::COUNT_W-1:0] capacity_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bist_pkg::CAPACITY_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   bist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bist_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_mode   (req_tuser),
      .req_key    (req_tdata),
      .capacity   (capacity_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a word is in progress");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[13:7]) <= 32'(DEPTH))
      else $error("count beyond depth");

   a_refused_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[14] && rsp_tdata[0]))
      else $error("refused add reported as found");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_add && (cmd.do_remove || cmd.do_move)))
      else $error("conflicting slot updates");

endmodule
